@@ sv/mgrw_pkg.sv @@
package mgrw_pkg;

    localparam int PIXEL_COORD_WIDTH = 16;
    localparam int DIVIDEND_WIDTH    = PIXEL_COORD_WIDTH + 2;
    localparam int TILE_WIDTH        = 10;
    localparam int GRID_WIDTH        = 20;
    localparam int CALC_WIDTH        = GRID_WIDTH + 2;
    localparam int GRID_OUT_WIDTH    = 19;
    localparam int MAP_WIDTH         = 17;
    localparam int DIV_STEPS         = DIVIDEND_WIDTH;
    localparam int DIV_CNT_WIDTH     = $clog2(DIV_STEPS);

    localparam int CFG_ADDR_WIDTH    = 4;
    localparam logic [1:0] REG_ISOMETRIC   = 2'd0;
    localparam logic [1:0] REG_HEX_MODE    = 2'd1;
    localparam logic [1:0] REG_TILE_WIDTH  = 2'd2;
    localparam logic [1:0] REG_TILE_HEIGHT = 2'd3;

    localparam logic [1:0] HEX_WIDTH  = 2'd1;
    localparam logic [1:0] HEX_HEIGHT = 2'd2;

    localparam logic [1:0] EDGE_NS = 2'd0;
    localparam logic [1:0] EDGE_WE = 2'd1;
    localparam logic [1:0] EDGE_UD = 2'd2;
    localparam logic [1:0] EDGE_LR = 2'd3;

    localparam logic REQ_START = 1'b0;

    typedef struct packed {
        logic                 is_tile;
        logic                 is_corner;
        logic                 is_edge;
        logic [1:0]           edge_kind;
        logic [MAP_WIDTH-1:0] first_map_x;
        logic [MAP_WIDTH-1:0] second_map_x;
        logic [MAP_WIDTH-1:0] first_map_y;
        logic [MAP_WIDTH-1:0] second_map_y;
    } t_cls;

    function automatic logic signed [CALC_WIDTH-1:0] tdiv4(
        input logic signed [CALC_WIDTH-1:0] v
    );
        logic signed [CALC_WIDTH-1:0] b;
        b = v + (v[CALC_WIDTH-1] ? CALC_WIDTH'(3) : CALC_WIDTH'(0));
        return b >>> 2;
    endfunction

    function automatic logic signed [CALC_WIDTH-1:0] tdiv2(
        input logic signed [CALC_WIDTH-1:0] v
    );
        logic signed [CALC_WIDTH-1:0] b;
        b = v + (v[CALC_WIDTH-1] ? CALC_WIDTH'(1) : CALC_WIDTH'(0));
        return b >>> 1;
    endfunction

endpackage

@@ sv/map_grid_rect_walker_top.sv @@
// grid rectangle walker
// input stream: tuser is the request kind (start or next), tdata carries the
// rectangle edges; a start request yields no output transaction, each next
// request yields exactly one output transaction
// output stream: tlast marks the end of the walk (all other fields zero),
// tuser holds the point class, tdata the grid point and neighbour map coords
// a start runs four floor divisions one after another on a single shared
// divider at one quotient bit per cycle, each division with its own load
// and write-back step
// on a square grid a next request goes straight to the output state; on an
// isometric one the skip state steps the shared cursor past odd parity points
// s_axis_tready is high only while the sequencer is idle
// a finished result sits in the output register; a new request is still
// accepted while it waits, but its result is held back until the first one
// is taken, so a stalled receiver stalls the sender after one next request
// reset clears config to isometric off, no hex, 64 x 32 tiles, and leaves
// nothing to walk: a next request then returns an end transaction
// config writes over the apb port complete without wait states (pready high)
module map_grid_rect_walker_top (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [mgrw_pkg::CFG_ADDR_WIDTH-1:0]      paddr,
    input  logic [31:0]                              pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // rect_left, rect_top, rect_right, rect_bottom
    input  logic [4*mgrw_pkg::PIXEL_COORD_WIDTH-1:0] s_axis_tdata,
    // req_type
    input  logic                                     s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // grid_x, grid_y, first_map_x, second_map_x, first_map_y, second_map_y
    output logic [111:0]                             m_axis_tdata,
    // is_tile, is_corner, is_edge, edge_kind
    output logic [4:0]                               m_axis_tuser,
    // at_end
    output logic                                     m_axis_tlast
);

    localparam int PW = mgrw_pkg::PIXEL_COORD_WIDTH;
    localparam int DW = mgrw_pkg::DIVIDEND_WIDTH;
    localparam int GW = mgrw_pkg::GRID_WIDTH;
    localparam int TW = mgrw_pkg::TILE_WIDTH;
    localparam int OW = mgrw_pkg::GRID_OUT_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_LOAD,
        ST_DIV_WAIT,
        ST_SKIP,
        ST_OUT
    } t_state;

    t_state r_state;

    logic          r_iso;
    logic [1:0]    r_hex;
    logic [TW-1:0] r_tw;
    logic [TW-1:0] r_th;

    logic signed [PW-1:0] r_left, r_top, r_right, r_bottom;
    logic signed [GW-1:0] r_xstart, r_xstop, r_ystart, r_ystop;
    logic signed [GW-1:0] r_cx, r_cy;
    logic                 r_walk;
    logic [1:0]           r_idx;
    logic                 r_neg;

    logic         r_out_valid;
    logic         r_out_last;
    logic [4:0]   r_out_user;
    logic [111:0] r_out_data;

    logic cfg_wr;
    logic s_acc, m_acc;

    logic signed [PW-1:0] in_l, in_t, in_r, in_b;

    logic [TW-1:0]        w_eff, h_eff, d_sel;
    logic signed [PW-1:0] edge_sel;
    logic signed [DW:0]   dvd, dvd_sh;
    logic [DW-1:0]        dvd_mag;

    logic          div_start, div_done, div_nz;
    logic [DW-1:0] div_quot;

    logic signed [GW-1:0] q_ext, fl, bound, adj;

    logic signed [GW-1:0] cx1, adv_cx, adv_cy, cy1;
    logic                 adv_walk;
    logic                 odd;

    mgrw_pkg::t_cls cls;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iso <= 1'b0;
            r_hex <= '0;
            r_tw  <= TW'(64);
            r_th  <= TW'(32);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                mgrw_pkg::REG_ISOMETRIC:   r_iso <= pwdata[0];
                mgrw_pkg::REG_HEX_MODE:    r_hex <= pwdata[1:0];
                mgrw_pkg::REG_TILE_WIDTH:  r_tw  <= pwdata[TW-1:0];
                mgrw_pkg::REG_TILE_HEIGHT: r_th  <= pwdata[TW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            mgrw_pkg::REG_ISOMETRIC:   prdata = {31'd0, r_iso};
            mgrw_pkg::REG_HEX_MODE:    prdata = {30'd0, r_hex};
            mgrw_pkg::REG_TILE_WIDTH:  prdata = {22'd0, r_tw};
            mgrw_pkg::REG_TILE_HEIGHT: prdata = {22'd0, r_th};
            default:                   prdata = '0;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_acc         = r_out_valid && m_axis_tready;

    assign in_l = s_axis_tdata[PW-1:0];
    assign in_t = s_axis_tdata[2*PW-1:PW];
    assign in_r = s_axis_tdata[3*PW-1:2*PW];
    assign in_b = s_axis_tdata[4*PW-1:3*PW];

    // dividend for the bound selected by r_idx: x start, y start, x stop, y stop
    assign w_eff = (r_tw == '0) ? TW'(1) : r_tw;
    assign h_eff = (r_th == '0) ? TW'(1) : r_th;

    always_comb begin
        case (r_idx)
            2'd0:    edge_sel = r_left;
            2'd1:    edge_sel = r_top;
            2'd2:    edge_sel = r_right;
            default: edge_sel = r_bottom;
        endcase
        d_sel   = r_idx[0] ? h_eff : w_eff;
        dvd_sh  = r_iso ? ((DW+1)'(edge_sel) <<< 2) : ((DW+1)'(edge_sel) <<< 1);
        dvd     = dvd_sh + (r_idx[1] ? (DW+1)'(d_sel - TW'(1)) : (DW+1)'(0));
        dvd_mag = dvd[DW] ? DW'(-dvd) : dvd[DW-1:0];
    end

    assign div_start = (r_state == ST_DIV_LOAD);

    mgrw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd_mag),
        .i_divisor  (d_sel),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem_nz   (div_nz)
    );

    // floor correction and grid offset
    always_comb begin
        q_ext = GW'(div_quot);
        fl    = r_neg ? (-q_ext - GW'(div_nz)) : q_ext;
        if (r_idx[1]) begin
            adj = r_iso ? GW'(2) : GW'(1);
        end else begin
            adj = r_iso ? -GW'(1) : GW'(0);
        end
        bound = fl + adj;
    end

    // cursor step in reading order
    always_comb begin
        cx1 = r_cx + GW'(1);
        cy1 = r_cy + GW'(1);
        if (cx1 >= r_xstop) begin
            adv_cx   = r_xstart;
            adv_cy   = cy1;
            adv_walk = !(cy1 >= r_ystop) && r_walk;
        end else begin
            adv_cx   = cx1;
            adv_cy   = r_cy;
            adv_walk = r_walk;
        end
        odd = r_cx[0] ^ r_cy[0];
    end

    mgrw_cls u_cls (
        .i_iso (r_iso),
        .i_hex (r_hex),
        .i_cx  (r_cx),
        .i_cy  (r_cy),
        .o_cls (cls)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_walk      <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
            r_out_user  <= '0;
            r_out_data  <= '0;
            r_idx       <= '0;
            r_neg       <= 1'b0;
            r_left      <= '0;
            r_top       <= '0;
            r_right     <= '0;
            r_bottom    <= '0;
            r_xstart    <= '0;
            r_xstop     <= '0;
            r_ystart    <= '0;
            r_ystop     <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
        end else begin
            if (m_acc && r_state != ST_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_acc) begin
                        if (s_axis_tuser == mgrw_pkg::REQ_START) begin
                            r_left   <= (in_r < in_l) ? in_r : in_l;
                            r_right  <= (in_r < in_l) ? in_l : in_r;
                            r_top    <= (in_b < in_t) ? in_b : in_t;
                            r_bottom <= (in_b < in_t) ? in_t : in_b;
                            r_idx    <= '0;
                            r_state  <= ST_DIV_LOAD;
                        end else if (r_iso) begin
                            r_state <= ST_SKIP;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_DIV_LOAD: begin
                    r_neg   <= dvd[DW];
                    r_state <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        case (r_idx)
                            2'd0:    r_xstart <= bound;
                            2'd1:    r_ystart <= bound;
                            2'd2:    r_xstop  <= bound;
                            default: r_ystop  <= bound;
                        endcase
                        if (r_idx == 2'd3) begin
                            r_cx    <= r_xstart;
                            r_cy    <= r_ystart;
                            r_walk  <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx + 2'd1;
                            r_state <= ST_DIV_LOAD;
                        end
                    end
                end
                ST_SKIP: begin
                    if (r_walk && odd) begin
                        r_cx   <= adv_cx;
                        r_cy   <= adv_cy;
                        r_walk <= adv_walk;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        if (r_walk) begin
                            r_out_last <= 1'b0;
                            r_out_user <= {cls.edge_kind, cls.is_edge, cls.is_corner,
                                           cls.is_tile};
                            r_out_data <= {6'd0, cls.second_map_y, cls.first_map_y,
                                           cls.second_map_x, cls.first_map_x,
                                           r_cy[OW-1:0], r_cx[OW-1:0]};
                            r_cx       <= adv_cx;
                            r_cy       <= adv_cy;
                            r_walk     <= adv_walk;
                        end else begin
                            r_out_last <= 1'b1;
                            r_out_user <= '0;
                            r_out_data <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ sv/mgrw_div.sv @@
module mgrw_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [mgrw_pkg::DIVIDEND_WIDTH-1:0]  i_dividend,
    input  logic [mgrw_pkg::TILE_WIDTH-1:0]      i_divisor,
    output logic                                 o_done,
    output logic [mgrw_pkg::DIVIDEND_WIDTH-1:0]  o_quot,
    output logic                                 o_rem_nz
);

    logic                                r_busy;
    logic                                r_done;
    logic [mgrw_pkg::DIV_CNT_WIDTH-1:0]  r_cnt;
    logic [mgrw_pkg::DIVIDEND_WIDTH-1:0] r_quo;
    logic [mgrw_pkg::TILE_WIDTH-1:0]     r_rem;
    logic [mgrw_pkg::TILE_WIDTH-1:0]     r_dvs;
    logic [mgrw_pkg::TILE_WIDTH:0]       trial;
    logic [mgrw_pkg::TILE_WIDTH:0]       diff;
    logic                                qbit;

    // one restoring step per cycle
    assign trial = {r_rem, r_quo[mgrw_pkg::DIVIDEND_WIDTH-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign qbit  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == mgrw_pkg::DIV_CNT_WIDTH'(mgrw_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[mgrw_pkg::DIVIDEND_WIDTH-2:0], qbit};
            r_rem <= qbit ? diff[mgrw_pkg::TILE_WIDTH-1:0] : trial[mgrw_pkg::TILE_WIDTH-1:0];
        end
    end

    assign o_done   = r_done;
    assign o_quot   = r_quo;
    assign o_rem_nz = (r_rem != '0);

endmodule

@@ sv/mgrw_cls.sv @@
module mgrw_cls (
    input  logic                                     i_iso,
    input  logic [1:0]                               i_hex,
    input  logic signed [mgrw_pkg::GRID_WIDTH-1:0]   i_cx,
    input  logic signed [mgrw_pkg::GRID_WIDTH-1:0]   i_cy,
    output mgrw_pkg::t_cls                           o_cls
);

    localparam int CW = mgrw_pkg::CALC_WIDTH;

    logic signed [CW-1:0] xe, ye, si, di;
    logic signed [CW-1:0] fx, sx, fy, sy;
    logic                 ht, hc, he;
    logic [1:0]           ek;

    always_comb begin
        xe = CW'(i_cx);
        ye = CW'(i_cy);
        si = xe + ye;
        di = ye - xe;
        fx = '0;
        sx = '0;
        fy = '0;
        sy = '0;
        ht = 1'b0;
        hc = 1'b0;
        he = 1'b0;
        ek = mgrw_pkg::EDGE_NS;
        if (i_iso) begin
            if (!i_cx[0] && !i_cy[0]) begin
                if (si[1:0] == 2'b00) begin
                    ht = 1'b1;
                    fx = mgrw_pkg::tdiv4(si) - CW'(1);
                    sx = fx;
                    fy = mgrw_pkg::tdiv4(di);
                    sy = fy;
                end else begin
                    hc = 1'b1;
                    fx = mgrw_pkg::tdiv4(si - CW'(6));
                    sx = mgrw_pkg::tdiv4(si - CW'(2));
                    fy = mgrw_pkg::tdiv4(di - CW'(2));
                    sy = mgrw_pkg::tdiv4(di + CW'(2));
                    if (i_hex == mgrw_pkg::HEX_WIDTH) begin
                        he = 1'b1;
                        ek = mgrw_pkg::EDGE_UD;
                    end else if (i_hex == mgrw_pkg::HEX_HEIGHT) begin
                        he = 1'b1;
                        ek = mgrw_pkg::EDGE_LR;
                    end
                end
            end else begin
                he = 1'b1;
                if (si[1:0] == 2'b00) begin
                    ek = mgrw_pkg::EDGE_NS;
                    fx = mgrw_pkg::tdiv4(si - CW'(4));
                    sx = fx;
                    fy = mgrw_pkg::tdiv4(di - CW'(2));
                    sy = mgrw_pkg::tdiv4(di + CW'(2));
                end else begin
                    ek = mgrw_pkg::EDGE_WE;
                    fx = mgrw_pkg::tdiv4(si - CW'(6));
                    sx = mgrw_pkg::tdiv4(si - CW'(2));
                    fy = mgrw_pkg::tdiv4(di);
                    sy = fy;
                end
            end
        end else begin
            if (!si[0]) begin
                if (!i_cx[0]) begin
                    hc = 1'b1;
                    fx = mgrw_pkg::tdiv2(xe) - CW'(1);
                    sx = mgrw_pkg::tdiv2(xe);
                    fy = mgrw_pkg::tdiv2(ye) - CW'(1);
                    sy = mgrw_pkg::tdiv2(ye);
                end else begin
                    ht = 1'b1;
                    fx = mgrw_pkg::tdiv2(xe - CW'(1));
                    sx = fx;
                    fy = mgrw_pkg::tdiv2(ye - CW'(1));
                    sy = fy;
                end
            end else begin
                he = 1'b1;
                if (!i_cy[0]) begin
                    ek = mgrw_pkg::EDGE_NS;
                    fx = mgrw_pkg::tdiv2(xe - CW'(1));
                    sx = fx;
                    fy = mgrw_pkg::tdiv2(ye) - CW'(1);
                    sy = mgrw_pkg::tdiv2(ye);
                end else begin
                    ek = mgrw_pkg::EDGE_WE;
                    fx = mgrw_pkg::tdiv2(xe) - CW'(1);
                    sx = mgrw_pkg::tdiv2(xe);
                    fy = mgrw_pkg::tdiv2(ye - CW'(1));
                    sy = fy;
                end
            end
        end
        o_cls.is_tile      = ht;
        o_cls.is_corner    = hc;
        o_cls.is_edge      = he;
        o_cls.edge_kind    = ek;
        o_cls.first_map_x  = fx[mgrw_pkg::MAP_WIDTH-1:0];
        o_cls.second_map_x = sx[mgrw_pkg::MAP_WIDTH-1:0];
        o_cls.first_map_y  = fy[mgrw_pkg::MAP_WIDTH-1:0];
        o_cls.second_map_y = sy[mgrw_pkg::MAP_WIDTH-1:0];
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam logic REQ_NEXT = ~mgrw_pkg::REQ_START;
    localparam int   N_PHASES = 9;
    localparam int   N_ITEMS = 1900;
    localparam int   SETTLE_CYCLES = 120;
    localparam int   HOLD_OFF_CYCLES = 400;

    typedef struct {
        logic        at_end;
        logic        is_tile;
        logic        is_corner;
        logic        is_edge;
        logic [1:0]  edge_kind;
        logic [18:0] grid_x;
        logic [18:0] grid_y;
        logic [16:0] first_map_x;
        logic [16:0] second_map_x;
        logic [16:0] first_map_y;
        logic [16:0] second_map_y;
    } t_grid_point;

    class t_grid_walk_board;
        bit         isometric;
        bit [1:0]   hex_mode;
        bit [9:0]   tile_w;
        bit [9:0]   tile_h;
        int         x_start, x_stop, y_start, y_stop, cur_x, cur_y;
        bit         walking;
        t_grid_point pending_points[$];
        int         errors, checked, n_tiles, n_corners, n_edges, n_ends;

        function new();
            isometric = 1'b0;
            hex_mode = 2'd0;
            tile_w = 10'd64;
            tile_h = 10'd32;
            walking = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, int value);
            case (idx)
                mgrw_pkg::REG_ISOMETRIC: isometric = value[0];
                mgrw_pkg::REG_HEX_MODE: hex_mode = value[1:0];
                mgrw_pkg::REG_TILE_WIDTH: tile_w = value[9:0];
                default: tile_h = value[9:0];
            endcase
        endfunction

        function int floor_quot(int a, int b);
            int q;
            q = a / b;
            if ((a % b) != 0 && a < 0)
                q--;
            return q;
        endfunction

        function void step_cursor();
            cur_x++;
            if (cur_x >= x_stop) begin
                cur_x = x_start;
                cur_y++;
                if (cur_y >= y_stop)
                    walking = 1'b0;
            end
        endfunction

        function void note_request(logic req, logic [63:0] rect);
            int l, t, r, b, r1, r2, w, h, tmp, xi, yi, si, di, fx, sx, fy, sy;
            t_grid_point p;
            if (req == mgrw_pkg::REQ_START) begin
                l = $signed(rect[15:0]);
                t = $signed(rect[31:16]);
                r = $signed(rect[47:32]);
                b = $signed(rect[63:48]);
                r1 = isometric ? 2 : 1;
                r2 = 2 * r1;
                w = (tile_w == 0) ? 1 : int'(tile_w);
                h = (tile_h == 0) ? 1 : int'(tile_h);
                if (r < l) begin
                    tmp = l; l = r; r = tmp;
                end
                if (b < t) begin
                    tmp = t; t = b; b = tmp;
                end
                x_start = floor_quot(l * r2, w) - r1 / 2;
                y_start = floor_quot(t * r2, h) - r1 / 2;
                x_stop = floor_quot(r * r2 + w - 1, w) + r1;
                y_stop = floor_quot(b * r2 + h - 1, h) + r1;
                cur_x = x_start;
                cur_y = y_start;
                walking = 1'b1;
                return;
            end
            p = '{default: '0};
            if (isometric)
                while (walking && ((cur_x + cur_y) & 1) != 0)
                    step_cursor();
            if (!walking) begin
                p.at_end = 1'b1;
                pending_points.push_back(p);
                return;
            end
            xi = cur_x;
            yi = cur_y;
            si = xi + yi;
            di = yi - xi;
            if (isometric) begin
                if (xi % 2 == 0 && yi % 2 == 0) begin
                    if (si % 4 == 0) begin
                        p.is_tile = 1'b1;
                        fx = si / 4 - 1; sx = fx;
                        fy = di / 4; sy = fy;
                    end else begin
                        p.is_corner = 1'b1;
                        fx = (si - 6) / 4; sx = (si - 2) / 4;
                        fy = (di - 2) / 4; sy = (di + 2) / 4;
                        if (hex_mode == mgrw_pkg::HEX_WIDTH) begin
                            p.is_edge = 1'b1;
                            p.edge_kind = mgrw_pkg::EDGE_UD;
                        end else if (hex_mode == mgrw_pkg::HEX_HEIGHT) begin
                            p.is_edge = 1'b1;
                            p.edge_kind = mgrw_pkg::EDGE_LR;
                        end
                    end
                end else begin
                    p.is_edge = 1'b1;
                    if (si % 4 == 0) begin
                        p.edge_kind = mgrw_pkg::EDGE_NS;
                        fx = (si - 4) / 4; sx = fx;
                        fy = (di - 2) / 4; sy = (di + 2) / 4;
                    end else begin
                        p.edge_kind = mgrw_pkg::EDGE_WE;
                        fx = (si - 6) / 4; sx = (si - 2) / 4;
                        fy = di / 4; sy = fy;
                    end
                end
            end else begin
                if (si % 2 == 0) begin
                    if (xi % 2 == 0) begin
                        p.is_corner = 1'b1;
                        fx = xi / 2 - 1; sx = xi / 2;
                        fy = yi / 2 - 1; sy = yi / 2;
                    end else begin
                        p.is_tile = 1'b1;
                        fx = (xi - 1) / 2; sx = fx;
                        fy = (yi - 1) / 2; sy = fy;
                    end
                end else begin
                    p.is_edge = 1'b1;
                    if (yi % 2 == 0) begin
                        p.edge_kind = mgrw_pkg::EDGE_NS;
                        fx = (xi - 1) / 2; sx = fx;
                        fy = yi / 2 - 1; sy = yi / 2;
                    end else begin
                        p.edge_kind = mgrw_pkg::EDGE_WE;
                        fx = xi / 2 - 1; sx = xi / 2;
                        fy = (yi - 1) / 2; sy = fy;
                    end
                end
            end
            p.grid_x = 19'(xi);
            p.grid_y = 19'(yi);
            p.first_map_x = 17'(fx);
            p.second_map_x = 17'(sx);
            p.first_map_y = 17'(fy);
            p.second_map_y = 17'(sy);
            pending_points.push_back(p);
            step_cursor();
        endfunction

        function void compare(string field, logic [18:0] want, logic [18:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch on %s at %0t: expected %h, got %h",
                             field, $realtime, want, got);
            end
        endfunction

        function void check_point(logic last, logic [4:0] user, logic [111:0] data);
            t_grid_point got, want;
            got.at_end = last;
            got.is_tile = user[0];
            got.is_corner = user[1];
            got.is_edge = user[2];
            got.edge_kind = user[4:3];
            got.grid_x = data[18:0];
            got.grid_y = data[37:19];
            got.first_map_x = data[54:38];
            got.second_map_x = data[71:55];
            got.first_map_y = data[88:72];
            got.second_map_y = data[105:89];
            if (pending_points.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transaction at %0t: last %b user %h data %h",
                             $realtime, last, user, data);
                return;
            end
            want = pending_points.pop_front();
            checked++;
            n_ends += want.at_end;
            n_tiles += want.is_tile;
            n_corners += want.is_corner;
            n_edges += want.is_edge;
            compare("at_end", want.at_end, got.at_end);
            compare("is_tile", want.is_tile, got.is_tile);
            compare("is_corner", want.is_corner, got.is_corner);
            compare("is_edge", want.is_edge, got.is_edge);
            compare("edge_kind", want.edge_kind, got.edge_kind);
            compare("grid_x", want.grid_x, got.grid_x);
            compare("grid_y", want.grid_y, got.grid_y);
            compare("first_map_x", want.first_map_x, got.first_map_x);
            compare("second_map_x", want.second_map_x, got.second_map_x);
            compare("first_map_y", want.first_map_y, got.first_map_y);
            compare("second_map_y", want.second_map_y, got.second_map_y);
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [mgrw_pkg::CFG_ADDR_WIDTH-1:0] paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // rect_left, rect_top, rect_right, rect_bottom
    logic [4*mgrw_pkg::PIXEL_COORD_WIDTH-1:0] s_axis_tdata = '0;
    // req_type
    logic                          s_axis_tuser = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // grid_x, grid_y, first_map_x, second_map_x, first_map_y, second_map_y
    logic [111:0]                  m_axis_tdata;
    // is_tile, is_corner, is_edge, edge_kind
    logic [4:0]                    m_axis_tuser;
    // at_end
    logic                          m_axis_tlast;

    t_grid_walk_board sb = new();
    bit             no_gaps = 1'b0;
    int             n_sent = 0;

    map_grid_rect_walker_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int idle_len();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_point(m_axis_tlast, m_axis_tuser, m_axis_tdata);
    end

    // receiver with one long hold-off once traffic is flowing
    initial begin
        int  stall;
        bit  held;
        held = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!held && sb.checked >= 300 && s_axis_tvalid) begin
                held = 1'b1;
                stall = HOLD_OFF_CYCLES;
            end else begin
                stall = idle_len();
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // tready always drops after an accept, so the idle edge costs nothing
    task automatic send_req(input logic req, input logic [63:0] rect);
        int gap;
        gap = idle_len();
        repeat (gap + 1) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= rect;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(req, rect);
        n_sent++;
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic next_req();
        send_req(REQ_NEXT, {$urandom, $urandom});
    endtask

    task automatic reg_write(input logic [1:0] idx, input int value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic wait_idle();
        while (sb.pending_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // rectangle up to one and a half tiles across, anywhere in pixel space, edges in either order
    function automatic logic [63:0] pick_rect();
        int w, h, sw, sh, l, t, r, b;
        w = (sb.tile_w == 0) ? 1 : int'(sb.tile_w);
        h = (sb.tile_h == 0) ? 1 : int'(sb.tile_h);
        sw = $urandom_range(0, w + w / 2);
        sh = $urandom_range(0, h + h / 2);
        case ($urandom_range(0, 9))
            0: l = -32768;
            1: l = 32767 - sw;
            default: l = int'($urandom_range(0, 65535 - sw)) - 32768;
        endcase
        case ($urandom_range(0, 9))
            0: t = -32768;
            1: t = 32767 - sh;
            default: t = int'($urandom_range(0, 65535 - sh)) - 32768;
        endcase
        r = l + sw;
        b = t + sh;
        if ($urandom_range(0, 1))
            return {16'(b), 16'(l), 16'(t), 16'(r)};
        return {16'(t), 16'(r), 16'(b), 16'(l)};
    endfunction

    task automatic walk_rect();
        int cut, n;
        send_req(mgrw_pkg::REQ_START, pick_rect());
        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 1000;
        n = 0;
        while (sb.walking && n < cut) begin
            next_req();
            n++;
        end
        repeat ($urandom_range(0, 2)) next_req();
    endtask

    task automatic noise();
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 2) == 0)
                send_req(mgrw_pkg::REQ_START, {$urandom, $urandom});
            else
                next_req();
        end
    endtask

    task automatic directed();
        next_req();
        next_req();
        send_req(mgrw_pkg::REQ_START, {16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
        repeat (3) next_req();
        send_req(mgrw_pkg::REQ_START, {16'h7fff, 16'h8000, 16'h8000, 16'h7fff});
        repeat (2) next_req();
        send_req(mgrw_pkg::REQ_START, 64'h0);
        repeat (2) next_req();
        send_req(mgrw_pkg::REQ_START, {4{16'hffff}});
        repeat (5) next_req();
    endtask

    initial begin
        int ph_iso[N_PHASES];
        int ph_hex[N_PHASES];
        int ph_tw[N_PHASES];
        int ph_th[N_PHASES];
        ph_iso = '{0, 1, 1, 0, 1, 0, 1, 0, 0};
        ph_hex = '{0, 1, 2, 3, 3, 1, 0, 0, 0};
        ph_tw = '{64, 64, 1, 1023, 0, 0, 1023, 0, 0};
        ph_th = '{32, 32, 1, 1023, 0, 7, 1, 0, 0};
        ph_iso[7] = $urandom_range(0, 1);
        ph_hex[7] = $urandom_range(0, 3);
        ph_tw[7] = $urandom_range(0, 1023);
        ph_th[7] = $urandom_range(0, 1023);
        ph_iso[8] = 1;
        ph_hex[8] = $urandom_range(1, 2);
        ph_tw[8] = $urandom_range(2, 40);
        ph_th[8] = $urandom_range(2, 40);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                wait_idle();
                reg_write(mgrw_pkg::REG_ISOMETRIC, ph_iso[p]);
                reg_write(mgrw_pkg::REG_HEX_MODE, ph_hex[p]);
                reg_write(mgrw_pkg::REG_TILE_WIDTH, ph_tw[p]);
                reg_write(mgrw_pkg::REG_TILE_HEIGHT, ph_th[p]);
            end
            no_gaps = (p == 2 || p == 5);
            if (p == 0)
                directed();
            while (n_sent < (p + 1) * N_ITEMS / N_PHASES) begin
                if ($urandom_range(0, 99) < 85)
                    walk_rect();
                else
                    noise();
            end
        end
        no_gaps = 1'b0;
        wait_idle();
        $display("%0d requests over %0d grid settings, %0d points checked",
                 n_sent, N_PHASES, sb.checked);
        $display("tiles %0d, corners %0d, edges %0d, end marks %0d, errors %0d",
                 sb.n_tiles, sb.n_corners, sb.n_edges, sb.n_ends, sb.errors);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ map_grid_rect_walker_top.f @@
sv/mgrw_pkg.sv
sv/mgrw_div.sv
sv/mgrw_cls.sv
sv/map_grid_rect_walker_top.sv
dv/testbench.sv
